FILE: hdl/rc_frame_decoder_key_classifier_assert.svh
// Assertion macros for the remote-control frame decoder.
// Included by the top level; needs nothing else.
`ifndef RC_FRAME_DECODER_KEY_CLASSIFIER_ASSERT_SVH
`define RC_FRAME_DECODER_KEY_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rcfd_pkg.sv
// Shared types and constants for the remote-control frame decoder.
// Used by every module of the block; depends on nothing.
package rcfd_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_FRAME_BYTES = 18;
   localparam int DEFAULT_KEY_COUNT   = 18;
   localparam int DEFAULT_HOLD_WIDTH  = 16;

   // Fixed frame layout.
   localparam int DECODE_BYTES   = 18;
   localparam int KEY_BITS       = 18;
   localparam int BYTE_WIDTH     = 8;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 184;
   localparam int RSP_USED_WIDTH = 179;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // Register reset values.
   localparam logic [9:0]  RESET_STICK_DEAD_BAND      = 10'd150;
   localparam logic [9:0]  RESET_WHEEL_LIMIT          = 10'd660;
   localparam logic [15:0] RESET_PRESS_THRESHOLD      = 16'd1;
   localparam logic [15:0] RESET_LONG_PRESS_THRESHOLD = 16'd50;

   // Wheel center offset.
   localparam logic signed [16:0] WHEEL_CENTER = 17'sd1024;

   // Register indexes.
   typedef enum logic [1:0] {
      REG_STICK_DEAD_BAND      = 2'd0,
      REG_WHEEL_LIMIT          = 2'd1,
      REG_PRESS_THRESHOLD      = 2'd2,
      REG_LONG_PRESS_THRESHOLD = 2'd3
   } reg_index_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [9:0]  stick_dead_band;
      logic [9:0]  wheel_limit;
      logic [15:0] press_threshold;
      logic [15:0] long_press_threshold;
   } cfg_type;

   // Bytes of the frame that the decode looks at.
   typedef logic [DECODE_BYTES-1:0][BYTE_WIDTH-1:0] frame_type;

   // Decoded frame fields.
   typedef struct packed {
      logic signed [10:0] stick_right_h;
      logic signed [10:0] stick_right_v;
      logic signed [10:0] stick_left_h;
      logic signed [10:0] stick_left_v;
      logic [3:0]         switch_pair;
      logic [47:0]        mouse_motion;
      logic signed [10:0] wheel_value;
      logic [KEY_BITS-1:0] raw_keys;
   } fields_type;

   // Per-key timing flags.
   typedef struct packed {
      logic [KEY_BITS-1:0] press;
      logic [KEY_BITS-1:0] long_press;
      logic [KEY_BITS-1:0] click;
   } key_flags_type;

endpackage

FILE: hdl/rcfd_frame_capture.sv
// Frame byte capture: buffer, write position and decode request.
// Depends on rcfd_pkg.
module rcfd_frame_capture #(
   parameter int FRAME_BYTES = rcfd_pkg::DEFAULT_FRAME_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            byte_accept,
   input  logic [rcfd_pkg::BYTE_WIDTH-1:0] byte_data,
   input  logic                            byte_last,
   input  logic                            decode_fire,
   output logic                            decode_pending,
   output rcfd_pkg::frame_type             frame_bytes
);

   localparam int IdxWidth = $clog2(FRAME_BYTES);
   localparam int PosWidth = $clog2(FRAME_BYTES + 1);

   logic [rcfd_pkg::BYTE_WIDTH-1:0] buffer_ff [FRAME_BYTES];
   logic [rcfd_pkg::BYTE_WIDTH-1:0] buffer_in [FRAME_BYTES];
   logic [PosWidth-1:0]             pos_ff, pos_in;
   logic                            pending_ff, pending_in;
   logic                            has_room;

   assign has_room = pos_ff < PosWidth'(FRAME_BYTES);

   // Store the byte while there is room; a closing byte rewinds the position.
   always_comb begin
      buffer_in = buffer_ff;
      pos_in    = pos_ff;
      if (byte_accept) begin
         if (has_room) begin
            buffer_in[pos_ff[IdxWidth-1:0]] = byte_data;
         end
         if (byte_last) begin
            pos_in = '0;
         end else if (has_room) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // A closing byte requests a decode; a new request wins over the retire.
   always_comb begin
      pending_in = pending_ff;
      if (decode_fire) begin
         pending_in = 1'b0;
      end
      if (byte_accept && byte_last) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            buffer_ff[i] <= '0;
         end
         pos_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         buffer_ff  <= buffer_in;
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
      end
   end

   // The decode reads a fixed set of leading bytes.
   always_comb begin
      for (int i = 0; i < rcfd_pkg::DECODE_BYTES; i++) begin
         frame_bytes[i] = buffer_ff[i];
      end
   end

   assign decode_pending = pending_ff;

endmodule

FILE: hdl/rcfd_field_decode.sv
// Field extraction from a captured frame: sticks, switches, mouse, wheel, keys.
// Depends on rcfd_pkg.
module rcfd_field_decode (
   input  rcfd_pkg::frame_type  frame_bytes,
   input  rcfd_pkg::cfg_type    cfg,
   output rcfd_pkg::fields_type fields
);

   // Re-center an 11-bit stick channel and apply the dead band.
   function automatic logic signed [10:0] stick_value(input logic [10:0] raw,
                                                     input logic [9:0] band);
      logic signed [11:0] v;
      logic signed [11:0] lim;
      v   = {~raw[10], ~raw[10], raw[9:0]};
      lim = $signed({2'b00, band});
      if (v <= lim && v >= -lim) begin
         return '0;
      end
      return v[10:0];
   endfunction

   logic [47:0]        stick_bits;
   logic [15:0]        wheel_raw;
   logic signed [16:0] wheel_centered;
   logic signed [16:0] wheel_lim;
   logic               wheel_out;

   // The four channels are packed little-endian over the first six bytes.
   assign stick_bits = {frame_bytes[5], frame_bytes[4], frame_bytes[3],
                        frame_bytes[2], frame_bytes[1], frame_bytes[0]};

   assign fields.stick_right_h = stick_value(stick_bits[10:0],  cfg.stick_dead_band);
   assign fields.stick_right_v = stick_value(stick_bits[21:11], cfg.stick_dead_band);
   assign fields.stick_left_h  = stick_value(stick_bits[32:22], cfg.stick_dead_band);
   assign fields.stick_left_v  = stick_value(stick_bits[43:33], cfg.stick_dead_band);

   // Left switch in the upper pair, right switch in the lower pair.
   assign fields.switch_pair = frame_bytes[5][7:4];

   assign fields.mouse_motion = {frame_bytes[11], frame_bytes[10], frame_bytes[9],
                                 frame_bytes[8], frame_bytes[7], frame_bytes[6]};

   // Wheel is re-centered and dropped when it lies outside the limit.
   assign wheel_raw      = {frame_bytes[17], frame_bytes[16]};
   assign wheel_centered = $signed({1'b0, wheel_raw}) - rcfd_pkg::WHEEL_CENTER;
   assign wheel_lim      = $signed({7'b0, cfg.wheel_limit});
   assign wheel_out      = (wheel_centered > wheel_lim) || (wheel_centered < -wheel_lim);
   assign fields.wheel_value = wheel_out ? 11'sd0 : wheel_centered[10:0];

   // Keys from two bytes, mouse buttons from bit zero of their bytes.
   assign fields.raw_keys = {frame_bytes[13][0], frame_bytes[12][0],
                             frame_bytes[15], frame_bytes[14]};

endmodule

FILE: hdl/rcfd_key_timer.sv
// Per-key hold counters with press, long-press and click flags.
// Depends on rcfd_pkg.
module rcfd_key_timer #(
   parameter int KEY_COUNT  = rcfd_pkg::DEFAULT_KEY_COUNT,
   parameter int HOLD_WIDTH = rcfd_pkg::DEFAULT_HOLD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic [rcfd_pkg::KEY_BITS-1:0] keys,
   input  rcfd_pkg::cfg_type             cfg,
   output rcfd_pkg::key_flags_type       flags_next
);

   localparam int CmpWidth = (HOLD_WIDTH > 16) ? HOLD_WIDTH : 16;

   logic [HOLD_WIDTH-1:0]   count_ff [KEY_COUNT];
   logic [HOLD_WIDTH-1:0]   count_in [KEY_COUNT];
   logic [HOLD_WIDTH-1:0]   count_inc [KEY_COUNT];
   rcfd_pkg::key_flags_type flags_ff, flags_in;
   logic [CmpWidth-1:0]     press_lim, long_lim;

   assign press_lim = CmpWidth'(cfg.press_threshold);
   assign long_lim  = CmpWidth'(cfg.long_press_threshold);

   // Saturating increment of each counter.
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         count_inc[i] = (&count_ff[i]) ? count_ff[i] : count_ff[i] + 1'b1;
      end
   end

   // Held keys count up and latch their flags; released keys settle the
   // click flag from the finished hold and start over.
   always_comb begin
      flags_in = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         count_in[i]            = count_ff[i];
         flags_in.press[i]      = flags_ff.press[i];
         flags_in.long_press[i] = flags_ff.long_press[i];
         flags_in.click[i]      = flags_ff.click[i];
         if (update) begin
            if (keys[i]) begin
               count_in[i] = count_inc[i];
               if (CmpWidth'(count_inc[i]) > press_lim) begin
                  flags_in.press[i] = 1'b1;
               end
               if (CmpWidth'(count_inc[i]) > long_lim) begin
                  flags_in.long_press[i] = 1'b1;
               end
            end else begin
               flags_in.click[i] = (CmpWidth'(count_ff[i]) > press_lim) &&
                                   (CmpWidth'(count_ff[i]) < long_lim);
               flags_in.press[i]      = 1'b0;
               flags_in.long_press[i] = 1'b0;
               count_in[i]            = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            count_ff[i] <= '0;
         end
         flags_ff <= '0;
      end else begin
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   assign flags_next = flags_in;

endmodule

FILE: hdl/rc_frame_decoder_key_classifier.sv
// Channel       | Dir | Transaction
// req_t*        | in  | one frame byte in tdata[7:0], tlast marks the last byte of a frame
// rsp_t*        | out | one decoded frame with key flags in tdata[178:0]
// csr_p*        | in  | register write or read, four registers in 32-bit words at 4*index
//
// A byte is taken every cycle while req_tready is high; a closing byte raises a decode
// request, and the decode writes its result into the output register.
// The decode pass sets the rate: while a decoded frame waits in the output register
// and another one is pending, req_tready is low until rsp_tready takes the first.
// Reset is synchronous; it clears the frame buffer, counters and flags and loads the registers with their reset values.
// Top level: registers, output stage and assertions; uses rcfd_pkg,
// rcfd_frame_capture, rcfd_field_decode, rcfd_key_timer and the assertion header.
`include "rc_frame_decoder_key_classifier_assert.svh"

module rc_frame_decoder_key_classifier #(
   parameter int FRAME_BYTES = rcfd_pkg::DEFAULT_FRAME_BYTES,
   parameter int KEY_COUNT   = rcfd_pkg::DEFAULT_KEY_COUNT,
   parameter int HOLD_WIDTH  = rcfd_pkg::DEFAULT_HOLD_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Byte stream in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: rx_byte [7:0]
   input  logic [rcfd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // tlast: frame_end
   input  logic                                req_tlast,
   // Decoded frames out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: stick_right_h [10:0], stick_right_v [21:11], stick_left_h [32:22],
   // stick_left_v [43:33], switch_pair [47:44], mouse_motion [95:48],
   // wheel_value [106:96], raw_keys [124:107], press_flags [142:125],
   // long_press_flags [160:143], click_flags [178:161], zero [183:179]
   output logic [rcfd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rcfd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [rcfd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [rcfd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   rcfd_pkg::cfg_type       cfg_ff, cfg_in;
   rcfd_pkg::reg_index_type csr_index;
   rcfd_pkg::frame_type     frame_bytes;
   rcfd_pkg::fields_type    fields;
   rcfd_pkg::key_flags_type flags_next;
   logic                    csr_write;
   logic                    req_accept;
   logic                    decode_pending;
   logic                    decode_fire;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [rcfd_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_index  = rcfd_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            rcfd_pkg::REG_STICK_DEAD_BAND:      cfg_in.stick_dead_band      = csr_pwdata[9:0];
            rcfd_pkg::REG_WHEEL_LIMIT:          cfg_in.wheel_limit          = csr_pwdata[9:0];
            rcfd_pkg::REG_PRESS_THRESHOLD:      cfg_in.press_threshold      = csr_pwdata[15:0];
            rcfd_pkg::REG_LONG_PRESS_THRESHOLD: cfg_in.long_press_threshold = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rcfd_pkg::REG_STICK_DEAD_BAND:      csr_prdata = {22'b0, cfg_ff.stick_dead_band};
         rcfd_pkg::REG_WHEEL_LIMIT:          csr_prdata = {22'b0, cfg_ff.wheel_limit};
         rcfd_pkg::REG_PRESS_THRESHOLD:      csr_prdata = {16'b0, cfg_ff.press_threshold};
         rcfd_pkg::REG_LONG_PRESS_THRESHOLD: csr_prdata = {16'b0, cfg_ff.long_press_threshold};
         default: csr_prdata = '0;
      endcase
   end

   // Handshake: the decode retires a pending frame whenever the output
   // register is free or being emptied; bytes wait while a frame cannot retire.
   assign decode_fire = decode_pending && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !decode_pending || decode_fire;
   assign req_accept  = req_tvalid && req_tready;

   rcfd_frame_capture #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_capture (
      .clock          (clock),
      .reset          (reset),
      .byte_accept    (req_accept),
      .byte_data      (req_tdata[7:0]),
      .byte_last      (req_tlast),
      .decode_fire    (decode_fire),
      .decode_pending (decode_pending),
      .frame_bytes    (frame_bytes)
   );

   rcfd_field_decode u_decode (
      .frame_bytes (frame_bytes),
      .cfg         (cfg_ff),
      .fields      (fields)
   );

   rcfd_key_timer #(
      .KEY_COUNT  (KEY_COUNT),
      .HOLD_WIDTH (HOLD_WIDTH)
   ) u_keys (
      .clock      (clock),
      .reset      (reset),
      .update     (decode_fire),
      .keys       (fields.raw_keys),
      .cfg        (cfg_ff),
      .flags_next (flags_next)
   );

   // Output register.
   assign rsp_data_in = {{(rcfd_pkg::RSP_DATA_WIDTH - rcfd_pkg::RSP_USED_WIDTH){1'b0}},
                         flags_next.click, flags_next.long_press, flags_next.press,
                         fields.raw_keys, fields.wheel_value, fields.mouse_motion,
                         fields.switch_pair, fields.stick_left_v, fields.stick_left_h,
                         fields.stick_right_v, fields.stick_right_h};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (decode_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_dead_band      <= rcfd_pkg::RESET_STICK_DEAD_BAND;
         cfg_ff.wheel_limit          <= rcfd_pkg::RESET_WHEEL_LIMIT;
         cfg_ff.press_threshold      <= rcfd_pkg::RESET_PRESS_THRESHOLD;
         cfg_ff.long_press_threshold <= rcfd_pkg::RESET_LONG_PRESS_THRESHOLD;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the pipeline control and on the key flags.
   `RCFD_ASSERT_NEXT(a_last_requests_decode, clock, reset, req_accept && req_tlast, decode_pending, "closing byte did not raise a decode request")
   `RCFD_ASSERT_NOW(a_stall_blocks_input, clock, reset, decode_pending && rsp_valid_ff && !rsp_tready, !req_tready, "input accepted while a decoded frame cannot retire")
   `RCFD_ASSERT_NOW(a_long_press_needs_key, clock, reset, rsp_tvalid, (rsp_tdata[160:143] & ~rsp_tdata[124:107]) == '0, "long press flag on a released key")

endmodule
